### rtl/core/signed_radix_digit_emitter_unit_assert.svh
// Assertion macros for the signed radix digit emitter.
`ifndef SIGNED_RADIX_DIGIT_EMITTER_UNIT_ASSERT_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define SRDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SRDE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define SRDE_ASSERT(lbl, prop, msg)

`define SRDE_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### rtl/core/srde_pkg.sv
// Shared types and constants for the signed radix digit emitter.
`default_nettype none

package srde_pkg;

  // Field and register widths
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned RADIX_LEN_W = 5;
  localparam int unsigned ALPHA_W     = 64;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned SYM_IDX_W   = 4;
  localparam int unsigned ALPHA_CHARS = 16;
  localparam int unsigned BIT_CNT_W   = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

  // Register reset values: radix 10, alphabet "0123456789ABCDEF"
  localparam logic [RADIX_LEN_W-1:0] RADIX_LEN_RST  = 5'd10;
  localparam logic [ALPHA_W-1:0]     ALPHA_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [ALPHA_W-1:0]     ALPHA_HIGH_RST = 64'h4645_4443_4241_3938;

  // Reserved characters
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic rd_issue;
    logic out_sign;
    logic out_zero;
    logic out_digit;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic alpha_ok;
    logic mag_zero;
    logic neg;
    logic div_last;
    logic store_full;
    logic store_empty;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/srde_datapath.sv
// Datapath: config registers, alphabet check, bit-serial divider, digit store, output register.
`default_nettype none

module srde_datapath #(
  parameter int unsigned MAX_RADIX   = 16,
  parameter int unsigned DIGIT_STORE = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [srde_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [srde_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [srde_pkg::VALUE_W-1:0] value_i,
  input  srde_pkg::cmd_t                      cmd_i,
  output srde_pkg::status_t                   status_o,
  output logic                                out_valid_o,
  output logic [srde_pkg::CHAR_W-1:0]         text_char_o,
  output logic                                last_char_o
);

  localparam int unsigned DIG_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int unsigned AW    = $clog2(DIGIT_STORE);
  localparam int unsigned CNT_W = $clog2(DIGIT_STORE + 1);
  localparam int unsigned CMP_W = srde_pkg::RADIX_LEN_W + 1;

  // Pick one alphabet character by index
  function automatic logic [srde_pkg::CHAR_W-1:0] sym_at(
    input logic [srde_pkg::ALPHA_W-1:0]   lo,
    input logic [srde_pkg::ALPHA_W-1:0]   hi,
    input logic [srde_pkg::SYM_IDX_W-1:0] k
  );
    logic [srde_pkg::ALPHA_W-1:0] word;
    word = k[3] ? hi : lo;
    return word[k[2:0]*8 +: 8];
  endfunction

  logic [srde_pkg::RADIX_LEN_W-1:0] radix_len_q;
  logic [srde_pkg::ALPHA_W-1:0]     alpha_low_q;
  logic [srde_pkg::ALPHA_W-1:0]     alpha_high_q;

  logic [srde_pkg::VALUE_W-1:0]     mag_q, mag_d;
  logic                             neg_q, neg_d;
  logic [DIG_W-1:0]                 rem_q, rem_d;
  logic [srde_pkg::BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [CNT_W-1:0]                 nd_q, nd_d;
  logic [CNT_W-1:0]                 nd_dec;
  logic [DIG_W-1:0]                 mem [DIGIT_STORE];
  logic [DIG_W-1:0]                 rd_data_q;

  logic                             out_valid_q, out_valid_d;
  logic [srde_pkg::CHAR_W-1:0]      char_q, char_d;
  logic                             last_q, last_d;

  logic [srde_pkg::VALUE_W-1:0]     raw;
  logic [DIG_W:0]                   rem_shift;
  logic                             q_bit;
  logic                             alpha_ok;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_len_q  <= srde_pkg::RADIX_LEN_RST;
      alpha_low_q  <= srde_pkg::ALPHA_LOW_RST;
      alpha_high_q <= srde_pkg::ALPHA_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srde_pkg::REG_RADIX_LEN:  radix_len_q  <= cfg_data_i[srde_pkg::RADIX_LEN_W-1:0];
        srde_pkg::REG_ALPHA_LOW:  alpha_low_q  <= cfg_data_i;
        srde_pkg::REG_ALPHA_HIGH: alpha_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Check the alphabet: length range, reserved characters, repeats
  always_comb begin
    logic [srde_pkg::CHAR_W-1:0] ca;
    alpha_ok = (radix_len_q >= srde_pkg::RADIX_LEN_W'(2))
            && (CMP_W'(radix_len_q) <= CMP_W'(MAX_RADIX));
    for (int a = 0; a < srde_pkg::ALPHA_CHARS; a++) begin
      ca = sym_at(alpha_low_q, alpha_high_q, srde_pkg::SYM_IDX_W'(a));
      if (srde_pkg::RADIX_LEN_W'(a) < radix_len_q) begin
        if (ca == srde_pkg::CHAR_MINUS || ca == srde_pkg::CHAR_PLUS ||
            ca == srde_pkg::CHAR_SPACE) begin
          alpha_ok = 1'b0;
        end
        for (int b = a + 1; b < srde_pkg::ALPHA_CHARS; b++) begin
          if (srde_pkg::RADIX_LEN_W'(b) < radix_len_q &&
              sym_at(alpha_low_q, alpha_high_q, srde_pkg::SYM_IDX_W'(b)) == ca) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // One restoring division step: shift in the next dividend bit, subtract if it fits
  assign raw       = $unsigned(value_i);
  assign rem_shift = {rem_q, mag_q[srde_pkg::VALUE_W-1]};
  assign q_bit     = CMP_W'(rem_shift) >= CMP_W'(radix_len_q);
  assign nd_dec    = nd_q - CNT_W'(1);

  always_comb begin
    mag_d     = mag_q;
    neg_d     = neg_q;
    rem_d     = rem_q;
    bit_cnt_d = bit_cnt_q;
    nd_d      = nd_q;
    if (cmd_i.load) begin
      neg_d     = raw[srde_pkg::VALUE_W-1];
      mag_d     = raw[srde_pkg::VALUE_W-1] ? (~raw + srde_pkg::VALUE_W'(1)) : raw;
      rem_d     = '0;
      bit_cnt_d = '0;
      nd_d      = '0;
    end else if (cmd_i.div_step) begin
      mag_d     = {mag_q[srde_pkg::VALUE_W-2:0], q_bit};
      rem_d     = q_bit ? DIG_W'(CMP_W'(rem_shift) - CMP_W'(radix_len_q))
                        : DIG_W'(rem_shift);
      bit_cnt_d = bit_cnt_q + srde_pkg::BIT_CNT_W'(1);
    end else if (cmd_i.push) begin
      rem_d     = '0;
      bit_cnt_d = '0;
      nd_d      = nd_q + CNT_W'(1);
    end else if (cmd_i.rd_issue) begin
      nd_d      = nd_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
      nd_q      <= '0;
    end else begin
      bit_cnt_q <= bit_cnt_d;
      nd_q      <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    rem_q <= rem_d;
  end

  // Digit store: write the remainder, read back in reverse order
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[nd_q[AW-1:0]] <= rem_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem[nd_dec[AW-1:0]];
    end
  end

  // Output register: one beat per strobe
  always_comb begin
    out_valid_d = cmd_i.out_sign | cmd_i.out_zero | cmd_i.out_digit;
    if (cmd_i.out_sign) begin
      char_d = srde_pkg::CHAR_MINUS;
      last_d = 1'b0;
    end else if (cmd_i.out_zero) begin
      char_d = sym_at(alpha_low_q, alpha_high_q, '0);
      last_d = 1'b1;
    end else begin
      char_d = sym_at(alpha_low_q, alpha_high_q, srde_pkg::SYM_IDX_W'(rd_data_q));
      last_d = (nd_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_d) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

  // Status to the controller
  assign status_o.alpha_ok    = alpha_ok;
  assign status_o.mag_zero    = (mag_q == '0);
  assign status_o.neg         = neg_q;
  assign status_o.div_last    = (bit_cnt_q == srde_pkg::BIT_CNT_W'(srde_pkg::VALUE_W - 1));
  assign status_o.store_full  = (nd_q == CNT_W'(DIGIT_STORE - 1));
  assign status_o.store_empty = (nd_q == '0);

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

### rtl/core/srde_ctrl.sv
// Controller: sequences load, sign, division per digit, and reverse emission.
`default_nettype none

module srde_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  srde_pkg::status_t status_i,
  output srde_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SIGN = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_PUSH = 6'b001000,
    ST_READ = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!status_i.alpha_ok) begin
          state_d = ST_IDLE;
        end else if (status_i.mag_zero) begin
          cmd_o.out_zero = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.out_sign = status_i.neg;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        if (status_i.mag_zero || status_i.store_full) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.out_digit = 1'b1;
        if (status_i.store_empty) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### rtl/core/signed_radix_digit_emitter_unit.sv
// Top level of the signed radix digit emitter: controller plus datapath.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+-------------------------
//  command  | value_i                                | start && !busy
//  result   | text_char_o, last_char_o               | out_valid_o, one cycle
//  config   | cfg_idx_i, cfg_data_i                  | cfg_we_i
//
// The unit takes no new item while busy; busy stays high until the item's final
// character is registered for output. For each digit the one-bit-per-cycle divider
// runs 32 steps and the remainder is then stored; the digits are read back from
// the digit store in reverse order. Zero, or an unusable alphabet, returns to idle
// from the sign check. The longest item is radix 2 at -2^31, with 32 digits.
// Reset clears the control state and loads the default radix and alphabet.
// Results cannot be held off; each beat is valid for exactly one cycle.
`default_nettype none

module signed_radix_digit_emitter_unit #(
  parameter int unsigned MAX_RADIX   = 16,
  parameter int unsigned DIGIT_STORE = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [srde_pkg::VALUE_W-1:0] value_i,
  output logic                                out_valid_o,
  output logic [srde_pkg::CHAR_W-1:0]         text_char_o,
  output logic                                last_char_o,
  input  logic                                cfg_we_i,
  input  logic [srde_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [srde_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

`include "signed_radix_digit_emitter_unit_assert.svh"

  srde_pkg::cmd_t    cmd;
  srde_pkg::status_t status;

  srde_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  srde_datapath #(
    .MAX_RADIX   (MAX_RADIX),
    .DIGIT_STORE (DIGIT_STORE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

  // An accepted command always occupies the unit in the next cycle
  `SRDE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")

  // Beats are never back to back: sign and digits are spaced by store or read cycles
  `SRDE_ASSERT(a_no_adjacent_beats, out_valid_o |=> !out_valid_o, "two result beats in a row")

  // The sign can never close a number, since a valid alphabet excludes it
  `SRDE_ASSERT_NEVER(a_sign_not_last,
    out_valid_o && last_char_o && (text_char_o == srde_pkg::CHAR_MINUS),
    "minus sign flagged as final character")

  // A strobe while idle can only be the final character of the item just done
  `SRDE_ASSERT(a_idle_beat_is_last, (out_valid_o && !busy) |-> last_char_o,
    "non-final beat while idle")

endmodule

`default_nettype wire
